@@ hdl/min_forward_price_drop_macros.svh @@
// Assertion macros for the minimum forward price drop block.
// Used by the top level; needs clk and rst_n in scope.
`ifndef MIN_FORWARD_PRICE_DROP_MACROS_SVH
`define MIN_FORWARD_PRICE_DROP_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define MFPD_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset
`define MFPD_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/mfpd_pkg.sv @@
// Shared constants and types for the minimum forward price drop block.
// No dependencies.
package mfpd_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int PRICE_BITS = 48;
  localparam int IW         = $clog2(MAX_ITEMS);
  localparam int CW         = $clog2(MAX_ITEMS + 1);
  // queue depth, a power of two
  localparam int QDEPTH     = 2;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QW         = $clog2(QDEPTH + 1);

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [IW-1:0]         idx_t;
  typedef logic [CW-1:0]         cnt_t;
  typedef logic [QW-1:0]         qcnt_t;

  // one queued word: price, end of set, dropped for lack of room
  typedef struct packed {
    price_t price;
    logic   last;
    logic   drop;
  } item_t;

  // one sorted store entry
  typedef struct packed {
    price_t price;
    idx_t   pos;
  } ent_t;

  // queue status seen by front and back
  typedef struct packed {
    logic  empty;
    logic  full;
    qcnt_t cnt;
  } qstat_t;

endpackage

@@ hdl/mfpd_front.sv @@
// Front part: accepts input words, marks those beyond capacity as dropped.
// Depends on mfpd_pkg.
module mfpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfpd_pkg::price_t   in_price,
  input  logic               in_last,
  input  mfpd_pkg::qstat_t   q_stat,
  output logic               q_push,
  output mfpd_pkg::item_t    q_item
);
  import mfpd_pkg::*;

  cnt_t count_r, count_nxt;
  logic accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign q_push   = accept;

  // classify: the store takes at most MAX_ITEMS prices per set
  always_comb begin
    q_item.price = in_price;
    q_item.last  = in_last;
    q_item.drop  = (count_r == cnt_t'(MAX_ITEMS));
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_last) begin
        count_nxt = '0;
      end else if (count_r != cnt_t'(MAX_ITEMS)) begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/mfpd_queue.sv @@
// Short queue between front and back parts.
// Depends on mfpd_pkg.
module mfpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mfpd_pkg::item_t  push_item,
  input  logic             pop,
  output mfpd_pkg::item_t  head,
  output mfpd_pkg::qstat_t stat
);
  import mfpd_pkg::*;

  item_t           store_r [QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  qcnt_t           cnt_r;

  assign head       = store_r[rp_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == qcnt_t'(QDEPTH));
  assign stat.cnt   = cnt_r;

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wp_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + qcnt_t'(push) - qcnt_t'(pop);
    end
  end

endmodule

@@ hdl/mfpd_engine.sv @@
// Back part: sorted insertion into the store, final neighbor scan, result word.
// Depends on mfpd_pkg.
module mfpd_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  mfpd_pkg::item_t  q_head,
  input  mfpd_pkg::qstat_t q_stat,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output mfpd_pkg::price_t out_best_drop,
  output logic             out_found,
  output logic             out_overflow
);
  import mfpd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_WR0, S_SCAN, S_EMIT} state_t;

  // sorted store, single port, registered read
  ent_t mem [MAX_ITEMS];
  ent_t rdata_r;
  logic we, re;
  idx_t addr;
  ent_t wdata;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   ovf_r, ovf_nxt;
  item_t  item_r, item_nxt;
  idx_t   k_r, k_nxt;
  cnt_t   j_r, j_nxt;
  logic   rv_r, rv_nxt;
  logic   hp_r, hp_nxt;
  ent_t   prev_r, prev_nxt;
  logic   fnd_r, fnd_nxt;
  price_t best_r, best_nxt;
  logic   ov_r, ov_nxt;
  price_t oml_r, oml_nxt;
  logic   ofd_r, ofd_nxt;
  logic   oof_r, oof_nxt;
  price_t loss;
  logic   cand;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata_r <= mem[addr];
  end

  // scan candidate: later arrival and strictly lower
  assign loss = prev_r.price - rdata_r.price;
  assign cand = (rdata_r.pos > prev_r.pos) && (prev_r.price > rdata_r.price);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    item_nxt  = item_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    rv_nxt    = 1'b0;
    hp_nxt    = hp_r;
    prev_nxt  = prev_r;
    fnd_nxt   = fnd_r;
    best_nxt  = best_r;
    ov_nxt    = ov_r && out_stall;
    oml_nxt   = oml_r;
    ofd_nxt   = ofd_r;
    oof_nxt   = oof_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    addr      = '0;
    wdata     = '{price: item_r.price, pos: cnt_r[IW-1:0]};

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          if (q_head.drop) begin
            ovf_nxt = 1'b1;
            if (q_head.last) state_nxt = S_SCAN;
          end else if (cnt_r == '0) begin
            we      = 1'b1;
            addr    = '0;
            wdata   = '{price: q_head.price, pos: '0};
            cnt_nxt = cnt_t'(1);
            if (q_head.last) state_nxt = S_SCAN;
          end else begin
            // walk down from the top of the store
            k_nxt     = cnt_r[IW-1:0];
            re        = 1'b1;
            addr      = cnt_r[IW-1:0] - idx_t'(1);
            state_nxt = S_CMP;
          end
          j_nxt    = '0;
          hp_nxt   = 1'b0;
          fnd_nxt  = 1'b0;
          best_nxt = '0;
        end
      end
      S_RD: begin
        re        = 1'b1;
        addr      = k_r - idx_t'(1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        we   = 1'b1;
        addr = k_r;
        if (rdata_r.price >= item_r.price) begin
          cnt_nxt   = cnt_r + cnt_t'(1);
          state_nxt = item_r.last ? S_SCAN : S_IDLE;
        end else begin
          // move the entry up one slot
          wdata     = rdata_r;
          k_nxt     = k_r - idx_t'(1);
          state_nxt = (k_r == idx_t'(1)) ? S_WR0 : S_RD;
        end
      end
      S_WR0: begin
        we        = 1'b1;
        addr      = '0;
        cnt_nxt   = cnt_r + cnt_t'(1);
        state_nxt = item_r.last ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        // stream reads, compare each entry with the one before it
        if (j_r < cnt_r) begin
          re     = 1'b1;
          addr   = j_r[IW-1:0];
          j_nxt  = j_r + cnt_t'(1);
          rv_nxt = 1'b1;
        end
        if (rv_r) begin
          if (hp_r && cand) begin
            fnd_nxt = 1'b1;
            if (!fnd_r || loss < best_r) best_nxt = loss;
          end
          prev_nxt = rdata_r;
          hp_nxt   = 1'b1;
        end
        if (j_r == cnt_r && !rv_r) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oml_nxt   = best_r;
          ofd_nxt   = fnd_r;
          oof_nxt   = ovf_r;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
    item_r <= item_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    hp_r   <= hp_nxt;
    prev_r <= prev_nxt;
    fnd_r  <= fnd_nxt;
    best_r <= best_nxt;
    oml_r  <= oml_nxt;
    ofd_r  <= ofd_nxt;
    oof_r  <= oof_nxt;
  end

  assign out_valid     = ov_r;
  assign out_best_drop = oml_r;
  assign out_found     = ofd_r;
  assign out_overflow  = oof_r;

endmodule

@@ hdl/min_forward_price_drop.sv @@
// Minimum forward price drop: accepts one price per word, keeps a sorted set
// in a single-port store and emits the smallest forward loss after the last
// word. A price into an empty store or a dropped word is settled as it is
// popped; other prices are compared from the top down, and each entry that
// must move up one slot is read and written back, all through the one store
// port. The final scan reads each stored entry in turn; the result then waits
// while the result register is held. A two-word queue lets input be taken
// while the back part works, and the result sits in an output register.
// Depends on mfpd_pkg, mfpd_front, mfpd_queue, mfpd_engine and the macros.
`include "min_forward_price_drop_macros.svh"
module min_forward_price_drop (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mfpd_pkg::price_t in_price,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output mfpd_pkg::price_t out_best_drop,
  output logic             out_found,
  output logic             out_overflow
);
  import mfpd_pkg::*;

  qstat_t q_stat;
  item_t  push_item, head;
  logic   push, pop;

  mfpd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_price(in_price), .in_last(in_last), .q_stat(q_stat),
    .q_push(push), .q_item(push_item)
  );

  mfpd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .stat(q_stat)
  );

  mfpd_engine u_engine (
    .clk(clk), .rst_n(rst_n), .q_head(head), .q_stat(q_stat), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_best_drop(out_best_drop),
    .out_found(out_found), .out_overflow(out_overflow)
  );

  `MFPD_ALWAYS(a_q_bound, q_stat.cnt <= qcnt_t'(QDEPTH), "queue count beyond depth")
  `MFPD_IMPLY(a_no_pop_empty, q_stat.empty, !pop, "pop from empty queue")
  `MFPD_IMPLY(a_empty_ready, q_stat.empty, !in_stall, "stall with empty queue")
  `MFPD_IMPLY(a_zero_loss, out_valid && !out_found, out_best_drop == '0, "loss without find")

endmodule

@@ verif/tb.sv @@
// Testbench for min_forward_price_drop: drives sets of prices, predicts the
// smallest forward drop per set and checks every result word. Needs mfpd_pkg.
`timescale 1ns / 100ps
module tb;
  import mfpd_pkg::*;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  price_t in_price;
  logic   in_last;
  logic   out_valid;
  logic   out_stall;
  price_t out_best_drop;
  logic   out_found;
  logic   out_overflow;

  min_forward_price_drop i_dut (.*);

  typedef struct {
    price_t loss;
    logic   found;
    logic   ovf;
  } loss_res_t;

  // predictor state: prices of the current set in arrival order
  price_t    set_prices[$];
  logic      set_dropped;
  loss_res_t loss_q[$];
  int        fails;
  int        n_words;
  int        n_results;
  longint    cycles;
  bit        long_hold;
  // typed-in expectation for directed rows
  bit        typed_on;
  loss_res_t typed_r;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sorted-descending scan, ties kept in arrival order
  function automatic loss_res_t predict_loss();
    price_t    srt[$];
    int        pos[$];
    int        j;
    loss_res_t r;
    r.loss = '0;
    r.found = 0;
    r.ovf = set_dropped;
    foreach (set_prices[k]) begin
      j = 0;
      while (j < srt.size() && srt[j] >= set_prices[k]) j++;
      srt.insert(j, set_prices[k]);
      pos.insert(j, k);
    end
    for (int i = 0; i + 1 < srt.size(); i++) begin
      if (pos[i+1] > pos[i] && srt[i] > srt[i+1]) begin
        if (!r.found || srt[i] - srt[i+1] < r.loss) r.loss = srt[i] - srt[i+1];
        r.found = 1;
      end
    end
    return r;
  endfunction

  // model one accepted word
  function automatic void take_word(price_t p, logic lst);
    if (set_prices.size() < MAX_ITEMS) set_prices.insert(set_prices.size(), p);
    else set_dropped = 1;
    if (lst) begin
      if (typed_on) loss_q.insert(loss_q.size(), typed_r);
      else loss_q.insert(loss_q.size(), predict_loss());
      set_prices.delete();
      set_dropped = 0;
    end
  endfunction

  // valid stays high across back-to-back words; dropped only for a gap
  task automatic send_word(price_t p, logic lst, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 11) : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_price <= p;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_word(p, lst);
    n_words++;
  endtask

  function automatic price_t rnd_price(int mode);
    case (mode)
      0: return price_t'({$urandom, $urandom});
      1: return price_t'($urandom_range(0, 20));
      default: return 48'hFFFF_FFFF_FFFF - price_t'($urandom_range(0, 20));
    endcase
  endfunction

  // directed rows: price, last, typed check, expected drop, expected found
  typedef struct {
    price_t p;
    logic   l;
    bit     chk;
    price_t e_loss;
    logic   e_found;
  } row_t;
  row_t dir_rows[15] = '{
    '{48'd5, 1'b1, 1'b1, 48'd0, 1'b0},                        // single price
    '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'd0, 1'b0},           // extremes
    '{48'd0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1},           // max drop
    '{48'd0, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 48'd0, 1'b0},           // rise only
    '{48'd7, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd7, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd7, 1'b1, 1'b1, 48'd0, 1'b0},                        // equal prices
    '{48'd20, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd15, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd8, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd5, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'd10, 1'b1, 1'b1, 48'd3, 1'b1},                       // mixed, min 3
    '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 48'd0, 1'b0},
    '{48'h5555_5555_5555, 1'b1, 1'b0, 48'd0, 1'b0}
  };

  // receiver: random stalls, plus one long hold
  initial begin
    int s;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        long_hold = 0;
        out_stall <= 0;
        @(posedge clk);
      end else begin
        s = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (s != 0) begin
          out_stall <= 1;
          repeat (s) @(posedge clk);
        end
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    loss_res_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (loss_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = loss_q.pop_front();
        if (out_best_drop !== e.loss) begin
          $error("best_drop exp %0h got %0h", e.loss, out_best_drop);
          fails++;
        end
        if (out_found !== e.found) begin
          $error("found exp %0b got %0b", e.found, out_found);
          fails++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow exp %0b got %0b", e.ovf, out_overflow);
          fails++;
        end
      end
    end
    if (cycles > 64'd30_000_000) begin
      $display("[min_forward_price_drop] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int len;
    int mode;
    int tout;
    fails = 0; n_words = 0; n_results = 0; cycles = 0;
    long_hold = 0; set_dropped = 0; typed_on = 0;
    typed_r.loss = '0; typed_r.found = 0; typed_r.ovf = 0;
    rst_n = 0; in_valid = 0; in_price = '0; in_last = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed table, typed-in results where given
    foreach (dir_rows[k]) begin
      typed_on = dir_rows[k].chk;
      typed_r.loss = dir_rows[k].e_loss;
      typed_r.found = dir_rows[k].e_found;
      typed_r.ovf = 0;
      send_word(dir_rows[k].p, dir_rows[k].l, 1);
    end
    typed_on = 0;
    // long receiver hold while words keep coming
    long_hold = 1;
    for (int k = 0; k < 40; k++) send_word(rnd_price(1), (k % 3) == 2, 0);
    in_valid <= 0;
    // sender pause until drained
    while (loss_q.size() != 0) @(posedge clk);
    // one overflow set: fill the store, last word dropped
    for (int k = 0; k <= MAX_ITEMS; k++)
      send_word(price_t'($urandom_range(0, 100000)), k == MAX_ITEMS, 0);
    // random sets, mostly short
    while (n_words < 1150) begin
      len = $urandom_range(0, 7) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 6);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) send_word(rnd_price(mode), k == len - 1, 1);
    end
    in_valid <= 0;
    tout = 0;
    while (loss_q.size() != 0 && tout < 200000) begin
      @(posedge clk);
      tout++;
    end
    repeat (3000) @(posedge clk);
    $display("Run covered %0d words and %0d result words, incl. a full-store set.",
      n_words, n_results);
    if (fails == 0 && loss_q.size() == 0) begin
      $display("[min_forward_price_drop] OK");
    end else begin
      $display("[min_forward_price_drop] ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mfpd_pkg.sv
hdl/mfpd_front.sv
hdl/mfpd_queue.sv
hdl/mfpd_engine.sv
hdl/min_forward_price_drop.sv
verif/tb.sv
